@@ rtl/core/fsms_pkg.sv @@
package fsms_pkg;

  localparam int unsigned MaxJobs     = 8;
  localparam int unsigned MaxMachines = 8;
  localparam int unsigned TimeBits    = 12;
  localparam int unsigned SpanBits    = 18;
  localparam int unsigned JobBits     = 3;
  localparam int unsigned MachBits    = 3;
  localparam int unsigned CountBits   = 4;
  localparam int unsigned AddrBits    = JobBits + MachBits;

  localparam logic [SpanBits-1:0] SpanMax = '1;

  localparam logic [2:0] RegJobCount     = 3'd0;
  localparam logic [2:0] RegMachineCount = 3'd4;

  typedef struct packed {
    logic init;
    logic order_start;
    logic step;
    logic compare;
    logic perm_scan;
    logic perm_swap;
    logic perm_rev;
  } cmd_t;

  typedef struct packed {
    logic step_last;
    logic scan_done;
    logic scan_found;
    logic rev_done;
  } status_t;

endpackage

@@ rtl/core/fsms_datapath.sv @@
module fsms_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  fsms_pkg::cmd_t                        cmd_i,
  output fsms_pkg::status_t                     status_o,
  output logic                                  pk_ok_o,
  input  logic [fsms_pkg::CountBits-1:0]        n_i,
  input  logic [fsms_pkg::CountBits-1:0]        m_i,
  input  logic                                  wr_en_i,
  input  logic [fsms_pkg::AddrBits-1:0]         wr_addr_i,
  input  logic [fsms_pkg::TimeBits-1:0]         wr_data_i,
  input  logic [fsms_pkg::JobBits-1:0]          out_pos_i,
  output logic [fsms_pkg::JobBits-1:0]          out_job_o,
  output logic [fsms_pkg::SpanBits-1:0]         best_span_o
);

  localparam int unsigned JB = fsms_pkg::JobBits;
  localparam int unsigned MB = fsms_pkg::MachBits;
  localparam int unsigned SB = fsms_pkg::SpanBits;

  logic [fsms_pkg::TimeBits-1:0] mem_q [fsms_pkg::MaxJobs*fsms_pkg::MaxMachines];
  logic [fsms_pkg::TimeBits-1:0] rd_q;
  logic [SB-1:0] fin_q [fsms_pkg::MaxMachines];
  logic [JB-1:0] cur_q [fsms_pkg::MaxJobs];
  logic [JB-1:0] best_q [fsms_pkg::MaxJobs];
  logic [SB-1:0] best_span_q;
  logic [SB-1:0] prev_q;
  logic [JB-1:0] pos_q;
  logic [MB-1:0] mach_q;
  logic          rd_vld_q;
  logic [MB-1:0] rd_mach_q;
  logic [JB-1:0] pi_q, pk_q, ri_q, rk_q;
  logic          found_i_q;

  logic [JB-1:0] last_pos, last_mach_w;
  logic [SB-1:0] start_v;
  logic [SB:0]   sum_v;
  logic [SB-1:0] fin_v;

  assign last_pos    = JB'(n_i - 4'd1);
  assign last_mach_w = MB'(m_i - 4'd1);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem_q[{cur_q[pos_q], mach_q}];
  end

  assign start_v = (rd_mach_q == '0) ? fin_q[rd_mach_q] :
                   ((prev_q > fin_q[rd_mach_q]) ? prev_q : fin_q[rd_mach_q]);
  assign sum_v   = {1'b0, start_v} + {{(SB-fsms_pkg::TimeBits+1){1'b0}}, rd_q};
  assign fin_v   = sum_v[SB] ? fsms_pkg::SpanMax : sum_v[SB-1:0];

  assign status_o.step_last  = (pos_q == last_pos) && (mach_q == last_mach_w);
  assign status_o.scan_done  = (pi_q == '0) || found_i_q;
  assign status_o.scan_found = found_i_q;
  assign status_o.rev_done   = !(ri_q < rk_q);
  assign pk_ok_o             = cur_q[pk_q] > cur_q[pi_q - 1'b1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q    <= 1'b0;
      best_span_q <= fsms_pkg::SpanMax;
      for (int i = 0; i < fsms_pkg::MaxJobs; i++) begin
        cur_q[i]  <= JB'(i);
        best_q[i] <= JB'(i);
      end
    end else begin
      rd_vld_q <= cmd_i.step;
      if (cmd_i.init) begin
        best_span_q <= fsms_pkg::SpanMax;
        for (int i = 0; i < fsms_pkg::MaxJobs; i++) begin
          cur_q[i]  <= JB'(i);
          best_q[i] <= JB'(i);
        end
      end
      if (cmd_i.compare && fin_q[last_mach_w] < best_span_q) begin
        best_span_q <= fin_q[last_mach_w];
        for (int i = 0; i < fsms_pkg::MaxJobs; i++) begin
          best_q[i] <= cur_q[i];
        end
      end
      if (cmd_i.perm_swap) begin
        cur_q[pi_q - 1'b1] <= cur_q[pk_q];
        cur_q[pk_q]        <= cur_q[pi_q - 1'b1];
      end else if (cmd_i.perm_rev && ri_q < rk_q) begin
        cur_q[ri_q] <= cur_q[rk_q];
        cur_q[rk_q] <= cur_q[ri_q];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.order_start) begin
      pos_q  <= '0;
      mach_q <= '0;
      for (int i = 0; i < fsms_pkg::MaxMachines; i++) begin
        fin_q[i] <= '0;
      end
      pi_q      <= last_pos;
      found_i_q <= 1'b0;
    end else if (cmd_i.step) begin
      if (mach_q == last_mach_w) begin
        mach_q <= '0;
        pos_q  <= pos_q + 1'b1;
      end else begin
        mach_q <= mach_q + 1'b1;
      end
    end
    if (rd_vld_q) begin
      fin_q[rd_mach_q] <= fin_v;
      prev_q           <= fin_v;
    end
    rd_mach_q <= mach_q;
    if (cmd_i.perm_scan) begin
      if (pi_q != '0 && !found_i_q) begin
        if (cur_q[pi_q - 1'b1] < cur_q[pi_q]) begin
          found_i_q <= 1'b1;
          pk_q      <= last_pos;
        end else begin
          pi_q <= pi_q - 1'b1;
        end
      end else if (found_i_q && !(cur_q[pk_q] > cur_q[pi_q - 1'b1])) begin
        pk_q <= pk_q - 1'b1;
      end
    end
    if (cmd_i.perm_swap) begin
      ri_q <= pi_q;
      rk_q <= last_pos;
    end else if (cmd_i.perm_rev && ri_q < rk_q) begin
      ri_q <= ri_q + 1'b1;
      rk_q <= rk_q - 1'b1;
    end
  end

  assign out_job_o   = best_q[out_pos_i];
  assign best_span_o = best_span_q;

endmodule

@@ rtl/core/fsms_ctrl.sv @@
module fsms_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [fsms_pkg::CountBits-1:0] n_i,
  input  fsms_pkg::status_t              status_i,
  input  logic                           pk_ok_i,
  output fsms_pkg::cmd_t                 cmd_o,
  output logic                           busy_o,
  output logic                           emit_o,
  input  logic                           emit_take_i,
  output logic [fsms_pkg::JobBits-1:0]   out_pos_o,
  output logic                           out_last_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StInit  = 4'd1;
  localparam logic [3:0] StOrd   = 4'd2;
  localparam logic [3:0] StStep  = 4'd3;
  localparam logic [3:0] StDrain = 4'd4;
  localparam logic [3:0] StCmp   = 4'd5;
  localparam logic [3:0] StScan  = 4'd6;
  localparam logic [3:0] StSwap  = 4'd7;
  localparam logic [3:0] StRev   = 4'd8;
  localparam logic [3:0] StEmit  = 4'd9;
  localparam logic [3:0] StWait  = 4'd10;

  logic [3:0] state_q, state_d;
  logic [fsms_pkg::JobBits-1:0] pos_q, pos_d;
  logic [fsms_pkg::JobBits-1:0] last_pos;

  assign last_pos = fsms_pkg::JobBits'(n_i - 4'd1);

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StInit;
        end
      end
      StInit: begin
        cmd_o.init = 1'b1;
        state_d    = StOrd;
      end
      StOrd: begin
        cmd_o.order_start = 1'b1;
        state_d           = StStep;
      end
      StStep: begin
        cmd_o.step = 1'b1;
        if (status_i.step_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StWait;
      end
      StWait: begin
        state_d = StCmp;
      end
      StCmp: begin
        cmd_o.compare = 1'b1;
        state_d       = StScan;
      end
      StScan: begin
        cmd_o.perm_scan = 1'b1;
        if (status_i.scan_done && !status_i.scan_found) begin
          state_d = StEmit;
          pos_d   = '0;
        end else if (status_i.scan_found && pk_ok_i) begin
          state_d = StSwap;
        end
      end
      StSwap: begin
        cmd_o.perm_swap = 1'b1;
        state_d         = StRev;
      end
      StRev: begin
        cmd_o.perm_rev = 1'b1;
        if (status_i.rev_done) begin
          state_d = StOrd;
        end
      end
      StEmit: begin
        if (emit_take_i) begin
          if (pos_q == last_pos) begin
            state_d = StIdle;
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

  assign busy_o     = (state_q != StIdle);
  assign emit_o     = (state_q == StEmit);
  assign out_pos_o  = pos_q;
  assign out_last_o = (pos_q == last_pos);

endmodule

@@ rtl/core/flow_shop_makespan_search_core.sv @@
// Channel  | Dir | tdata (low bit first)                            | tuser | tlast
// s_axis   | in  | job_index[2:0] machine_index[5:3] proc_time[17:6]| -     | last_entry
// m_axis   | out | position[2:0] job_number[6:3] best_makespan[24:7]| -     | last
// apb      | cfg | 0x0 job_count, 0x4 machine_count                  | -     | -
// A table entry is taken each cycle while the block is idle.
// The search runs over all n! job orders, limited by the single time-table read port and
// add/compare per cycle; then n results are given.
// s_axis_tready is low from the last entry until the final result is taken.
// Reset clears counts to one and the controller to idle; the table is not cleared.
module flow_shop_makespan_search_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // job_index, machine_index, proc_time
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // position, job_number, best_makespan
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0] job_count_q, machine_count_q;
  logic [3:0] n_c, m_c;
  logic       take, busy, emit, start;
  logic       pk_ok;
  fsms_pkg::cmd_t    cmd;
  fsms_pkg::status_t status;
  logic [2:0]  out_pos, out_job;
  logic [17:0] best_span;
  logic        out_last;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_count_q     <= 4'd1;
      machine_count_q <= 4'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        fsms_pkg::RegJobCount:     job_count_q     <= pwdata[3:0];
        fsms_pkg::RegMachineCount: machine_count_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      fsms_pkg::RegJobCount:     prdata = {28'd0, job_count_q};
      fsms_pkg::RegMachineCount: prdata = {28'd0, machine_count_q};
      default:                   prdata = '0;
    endcase
  end

  assign n_c = (job_count_q == 4'd0) ? 4'd1 : (job_count_q > 4'd8 ? 4'd8 : job_count_q);
  assign m_c = (machine_count_q == 4'd0) ? 4'd1 :
               (machine_count_q > 4'd8 ? 4'd8 : machine_count_q);

  assign s_axis_tready = !busy;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign start         = take && s_axis_tlast;

  fsms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .n_i         (n_c),
    .status_i    (status),
    .pk_ok_i     (pk_ok),
    .cmd_o       (cmd),
    .busy_o      (busy),
    .emit_o      (emit),
    .emit_take_i (m_axis_tready),
    .out_pos_o   (out_pos),
    .out_last_o  (out_last)
  );

  fsms_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .pk_ok_o     (pk_ok),
    .n_i         (n_c),
    .m_i         (m_c),
    .wr_en_i     (take),
    .wr_addr_i   (s_axis_tdata[5:0] == 6'd0 ? 6'd0 :
                  {s_axis_tdata[2:0], s_axis_tdata[5:3]}),
    .wr_data_i   (s_axis_tdata[17:6]),
    .out_pos_i   (out_pos),
    .out_job_o   (out_job),
    .best_span_o (best_span)
  );

  assign m_axis_tvalid = emit;
  assign m_axis_tdata  = {7'd0, best_span, {1'b0, out_job} + 4'd1, out_pos};
  assign m_axis_tlast  = out_last;

endmodule

@@ rtl/core/fsms_checker.sv @@
module fsms_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input open while results pending");

  a_start_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("search did not start");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_job_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[6:3] != 4'd0) else $error("job number zero");

  a_first_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> m_axis_tdata[2:0] == 3'd0) else $error("bad first position");

endmodule

bind flow_shop_makespan_search_core fsms_checker u_fsms_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
